// ===== rtl/pmct_pkg.sv =====
// Shared types, constants and register indexes for the mouse packet cursor tracker.
package pmct_pkg;

  localparam int SCREEN_LIMIT_DEF = 4096;
  localparam int RESET_WIDTH      = 640;
  localparam int RESET_HEIGHT     = 480;
  localparam int FIFO_DEPTH       = 2;

  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int POS_W      = 12;
  localparam int BTN_W      = 3;
  localparam int CNT_W      = 32;

  localparam logic [7:0]       START_MARK  = 8'h08;
  localparam logic [BTN_W-1:0] BUTTON_MASK = 3'd7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

  // Position of the next mouse byte within a packet.
  typedef enum logic [1:0] {
    BP_START,
    BP_DX,
    BP_DY
  } byte_pos_t;

  // A complete packet handed from the front end to the cursor unit.
  typedef struct packed {
    logic [BTN_W-1:0] buttons;
    logic [7:0]       dx;
    logic [7:0]       dy;
    logic [CNT_W-1:0] bytes_seen;
  } pkt_t;

  // One finished result word.
  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [BTN_W-1:0] button_bits;
    logic [CNT_W-1:0] packets_seen;
    logic [CNT_W-1:0] bytes_seen;
  } res_t;

endpackage

// ===== rtl/pmct_fifo.sv =====
// Small synchronous queue with full and empty flags.
module pmct_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  // DEPTH must be a power of two, two or more, so the pointers wrap by themselves.
  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/pmct_front.sv =====
// Front end: filters mouse bytes, counts them and assembles three-byte packets.
module pmct_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              from_aux,
  output logic              pkt_push,
  output pmct_pkg::pkt_t    pkt
);
  import pmct_pkg::*;

  byte_pos_t        pos_r;
  byte_pos_t        pos_nxt;
  logic [7:0]       held0_r;
  logic [7:0]       held1_r;
  logic [CNT_W-1:0] byte_total_r;
  logic [CNT_W-1:0] byte_total_inc;
  logic             mouse_byte;

  assign mouse_byte     = accept && from_aux;
  assign byte_total_inc = byte_total_r + CNT_W'(1);

  always_comb begin
    pos_nxt  = pos_r;
    pkt_push = 1'b0;
    pkt      = '{buttons: held0_r[BTN_W-1:0] & BUTTON_MASK, dx: held1_r, dy: data_byte,
                 bytes_seen: byte_total_inc};
    if (mouse_byte) begin
      case (pos_r)
        BP_START: begin
          if ((data_byte & START_MARK) != 8'h00) begin
            pos_nxt = BP_DX;
          end
        end
        BP_DX: begin
          pos_nxt = BP_DY;
        end
        BP_DY: begin
          pos_nxt  = BP_START;
          pkt_push = 1'b1;
        end
        default: begin
          pos_nxt = BP_START;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= BP_START;
      byte_total_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      if (mouse_byte) begin
        byte_total_r <= byte_total_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mouse_byte && pos_r == BP_START) begin
      held0_r <= data_byte;
    end
    if (mouse_byte && pos_r == BP_DX) begin
      held1_r <= data_byte;
    end
  end

endmodule

// ===== rtl/pmct_back.sv =====
// Back end: moves and clamps the cursor for each packet and forms the result word.
module pmct_back #(
  parameter int SCREEN_LIMIT = pmct_pkg::SCREEN_LIMIT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pkt_valid,
  input  pmct_pkg::pkt_t      pkt,
  output logic                pkt_pop,
  input  logic [$clog2(((SCREEN_LIMIT > pmct_pkg::RESET_WIDTH) ? SCREEN_LIMIT
                        : pmct_pkg::RESET_WIDTH) + 1)-1:0] screen_width,
  input  logic [$clog2(((SCREEN_LIMIT > pmct_pkg::RESET_WIDTH) ? SCREEN_LIMIT
                        : pmct_pkg::RESET_WIDTH) + 1)-1:0] screen_height,
  input  logic                res_full,
  output logic                res_push,
  output pmct_pkg::res_t      res
);
  import pmct_pkg::*;

  localparam int SIZE_MAX = (SCREEN_LIMIT > RESET_WIDTH) ? SCREEN_LIMIT : RESET_WIDTH;
  localparam int SW       = $clog2(SIZE_MAX + 1);
  localparam int CW       = $clog2(SIZE_MAX);
  localparam int EW       = CW + 2;

  logic [CW-1:0]    col_r;
  logic [CW-1:0]    row_r;
  logic [CW-1:0]    col_nxt;
  logic [CW-1:0]    row_nxt;
  logic [CNT_W-1:0] packet_total_r;
  logic [CNT_W-1:0] packet_total_inc;
  logic [CW-1:0]    col_hi;
  logic [CW-1:0]    row_hi;
  logic signed [EW-1:0] col_sum;
  logic signed [EW-1:0] row_sum;

  assign pkt_pop  = pkt_valid && !res_full;
  assign res_push = pkt_pop;

  // Sizes are at least one, so size minus one fits the cursor width.
  assign col_hi = CW'(screen_width - SW'(1));
  assign row_hi = CW'(screen_height - SW'(1));

  assign col_sum = $signed({2'b00, col_r}) + EW'($signed(pkt.dx));
  assign row_sum = $signed({2'b00, row_r}) - EW'($signed(pkt.dy));

  always_comb begin
    if (col_sum < 0) begin
      col_nxt = '0;
    end else if (col_sum > $signed({2'b00, col_hi})) begin
      col_nxt = col_hi;
    end else begin
      col_nxt = col_sum[CW-1:0];
    end
    if (row_sum < 0) begin
      row_nxt = '0;
    end else if (row_sum > $signed({2'b00, row_hi})) begin
      row_nxt = row_hi;
    end else begin
      row_nxt = row_sum[CW-1:0];
    end
  end

  assign packet_total_inc = packet_total_r + CNT_W'(1);

  always_comb begin
    res.pos_x        = POS_W'(col_nxt);
    res.pos_y        = POS_W'(row_nxt);
    res.button_bits  = pkt.buttons;
    res.packets_seen = packet_total_inc;
    res.bytes_seen   = pkt.bytes_seen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r          <= CW'(RESET_WIDTH / 2);
      row_r          <= CW'(RESET_HEIGHT / 2);
      packet_total_r <= '0;
    end else if (pkt_pop) begin
      col_r          <= col_nxt;
      row_r          <= row_nxt;
      packet_total_r <= packet_total_inc;
    end
  end

endmodule

// ===== rtl/ps2_mouse_packet_cursor_tracker.sv =====
// Top level of the PS/2 mouse packet decoder with a clamped cursor.
//
// This block takes one received controller byte per word on its input queue
// port, together with a flag that marks bytes from the mouse port. Other bytes
// are dropped without effect. Every mouse byte is counted. A packet begins
// only on a byte with bit 3 set; its third byte completes it, and then the
// signed X delta is added to the cursor column and the signed Y delta is
// subtracted from the row, both clamped to the configured screen. One result
// word per packet carries the cursor, the three button bits and the running
// packet and byte counts, which wrap at 32 bits. An input word is taken every
// cycle while full is low. The front end classifies a byte in its cycle, a
// finished packet passes through a two-entry queue to the cursor unit, which
// updates the cursor as it pops the packet, and the result waits in a two-entry
// output queue; a result is visible once written through both queues in turn.
// full rises only when the packet queue is full, which needs the output side
// to stall. Screen width and height reset to 640 and 480 with the cursor
// centered; written sizes are saturated to 1..SCREEN_LIMIT. The configuration
// port is always ready and must be written only while the block is idle.
module ps2_mouse_packet_cursor_tracker #(
  parameter int SCREEN_LIMIT = pmct_pkg::SCREEN_LIMIT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic [7:0]                          in_data_byte,
  input  logic                                in_from_aux,
  output logic                                empty,
  input  logic                                pop,
  output logic [pmct_pkg::POS_W-1:0]          out_pos_x,
  output logic [pmct_pkg::POS_W-1:0]          out_pos_y,
  output logic [pmct_pkg::BTN_W-1:0]          out_button_bits,
  output logic [pmct_pkg::CNT_W-1:0]          out_packets_seen,
  output logic [pmct_pkg::CNT_W-1:0]          out_bytes_seen,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pmct_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pmct_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pmct_pkg::*;

  // The size registers must hold both the reset sizes and the largest written size.
  localparam int SIZE_MAX = (SCREEN_LIMIT > RESET_WIDTH) ? SCREEN_LIMIT : RESET_WIDTH;
  localparam int SW       = $clog2(SIZE_MAX + 1);

  logic [SW-1:0] width_r;
  logic [SW-1:0] height_r;
  logic [SW-1:0] cfg_size;
  logic [31:0]   cfg_wide;

  logic  accept;
  logic  pkt_push;
  pkt_t  pkt_in;
  logic  pkt_full;
  logic  pkt_empty;
  logic  pkt_pop;
  pkt_t  pkt_out;
  logic  res_push;
  res_t  res_in;
  logic  res_full;
  res_t  res_out;

  // Configuration: a write of zero acts as one, and anything above the limit
  // is held at the limit.
  assign cfg_ready = 1'b1;
  assign cfg_wide  = 32'(cfg_data);

  always_comb begin
    if (cfg_wide == 32'd0) begin
      cfg_size = SW'(1);
    end else if (cfg_wide > 32'(SCREEN_LIMIT)) begin
      cfg_size = SW'(SCREEN_LIMIT);
    end else begin
      cfg_size = SW'(cfg_wide);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SW'(RESET_WIDTH);
      height_r <= SW'(RESET_HEIGHT);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  width_r  <= cfg_size;
        REG_SCREEN_HEIGHT: height_r <= cfg_size;
        default: ;
      endcase
    end
  end

  // The input side stalls only when the packet queue cannot take another packet.
  assign full   = pkt_full;
  assign accept = push && !full;

  pmct_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_data_byte),
    .from_aux  (in_from_aux),
    .pkt_push  (pkt_push),
    .pkt       (pkt_in)
  );

  pmct_fifo #(
    .WIDTH ($bits(pkt_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_pkt_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (pkt_push),
    .wdata (pkt_in),
    .full  (pkt_full),
    .pop   (pkt_pop),
    .rdata (pkt_out),
    .empty (pkt_empty)
  );

  pmct_back #(
    .SCREEN_LIMIT (SCREEN_LIMIT)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pkt_valid     (!pkt_empty),
    .pkt           (pkt_out),
    .pkt_pop       (pkt_pop),
    .screen_width  (width_r),
    .screen_height (height_r),
    .res_full      (res_full),
    .res_push      (res_push),
    .res           (res_in)
  );

  pmct_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign out_pos_x        = res_out.pos_x;
  assign out_pos_y        = res_out.pos_y;
  assign out_button_bits  = res_out.button_bits;
  assign out_packets_seen = res_out.packets_seen;
  assign out_bytes_seen   = res_out.bytes_seen;

endmodule

// ===== test/ps2_mouse_packet_cursor_tracker_tb.sv =====
// Self-checking testbench for the PS/2 mouse packet cursor tracker.
`timescale 1ns / 1ps

module ps2_mouse_packet_cursor_tracker_tb;
  import pmct_pkg::*;

  // Cycles allowed for a dropped byte or a partial packet to settle inside the
  // block once the last report has come out. The result path is only the packet
  // queue and the output queue, so this leaves a wide margin.
  localparam int SETTLE_CYCLES = 10;
  // Length of the receiver hold-off that fills the block and stalls its input.
  localparam int HOLD_CYCLES   = 80;
  // Mouse bytes queued per half phase of random traffic.
  localparam int HALF_PHASE    = 128;
  localparam int PHASES        = 4;
  // Timeout in ns at a 2 ns clock period, far beyond the slowest correct run.
  localparam int TIMEOUT_NS    = 2_000_000;

  // One byte waiting to be offered to the block.
  typedef struct packed {
    logic [7:0] data;
    logic       aux;
  } mouse_byte_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  logic [7:0]            in_data_byte = 8'h00;
  logic                  in_from_aux = 1'b0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [POS_W-1:0]      out_pos_x;
  logic [POS_W-1:0]      out_pos_y;
  logic [BTN_W-1:0]      out_button_bits;
  logic [CNT_W-1:0]      out_packets_seen;
  logic [CNT_W-1:0]      out_bytes_seen;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_SCREEN_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Bytes not yet offered, and cursor reports predicted but not yet seen.
  mouse_byte_t byte_backlog[$];
  res_t        cursor_reports_due[$];
  int          mismatches = 0;

  // Idle and stall rates in percent, changed only between phases.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // The receiver hold-off runs in its own process; the stimulus toggles
  // hold_req to start one, and hold_seen records that it has been taken.
  bit hold_req  = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  // Our own copy of the tracker state and its screen size.
  int             scr_width   = RESET_WIDTH;
  int             scr_height  = RESET_HEIGHT;
  byte_pos_t      next_pos    = BP_START;
  logic [7:0]     held_head   = 8'h00;
  logic [7:0]     held_dx     = 8'h00;
  int             cur_col     = RESET_WIDTH / 2;
  int             cur_row     = RESET_HEIGHT / 2;
  logic [CNT_W-1:0] packets_tally = '0;
  logic [CNT_W-1:0] bytes_tally   = '0;

  ps2_mouse_packet_cursor_tracker i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_data_byte     (in_data_byte),
    .in_from_aux      (in_from_aux),
    .empty            (empty),
    .pop              (pop),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_button_bits  (out_button_bits),
    .out_packets_seen (out_packets_seen),
    .out_bytes_seen   (out_bytes_seen),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // A written size is saturated to the range the block supports.
  function automatic int saturate_size(input logic [CFG_DATA_W-1:0] v);
    if (v == '0) return 1;
    if (v > SCREEN_LIMIT_DEF) return SCREEN_LIMIT_DEF;
    return int'(v);
  endfunction

  // Advances the tracker copy by one accepted byte. Returns 1 and fills rep
  // when the byte completes a packet; dropped bytes, stray start bytes and the
  // first two bytes of a packet give no report.
  function automatic bit track_mouse_byte(input logic [7:0] b, input logic aux,
                                          output res_t rep);
    int col;
    int row;
    rep = '0;
    if (!aux) return 1'b0;
    bytes_tally = bytes_tally + 1'b1;
    case (next_pos)
      BP_START: begin
        // Only a byte with the start mark may open a packet.
        if ((b & START_MARK) == '0) return 1'b0;
        held_head = b;
        next_pos  = BP_DX;
        return 1'b0;
      end
      BP_DX: begin
        held_dx  = b;
        next_pos = BP_DY;
        return 1'b0;
      end
      default: begin
        // X moves right with a positive delta; Y is up-positive on the wire
        // but rows grow downward, hence the subtraction.
        col = cur_col + int'(signed'(held_dx));
        row = cur_row - int'(signed'(b));
        if (col < 0) col = 0;
        else if (col > scr_width - 1) col = scr_width - 1;
        if (row < 0) row = 0;
        else if (row > scr_height - 1) row = scr_height - 1;
        cur_col       = col;
        cur_row       = row;
        packets_tally = packets_tally + 1'b1;
        next_pos      = BP_START;
        rep.pos_x        = cur_col[POS_W-1:0];
        rep.pos_y        = cur_row[POS_W-1:0];
        rep.button_bits  = held_head[BTN_W-1:0] & BUTTON_MASK;
        rep.packets_seen = packets_tally;
        rep.bytes_seen   = bytes_tally;
        return 1'b1;
      end
    endcase
  endfunction

  // Driver. The word on the input ports is predicted at the edge that takes
  // it; a refused word stays on the ports unchanged until it is taken.
  always @(posedge clk) begin : drive_bytes
    mouse_byte_t nxt;
    res_t        rep;
    bit          took;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      took = push && !full;
      if (took && track_mouse_byte(in_data_byte, in_from_aux, rep))
        cursor_reports_due.push_back(rep);
      if (!push || took) begin
        if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = byte_backlog.pop_front();
          push         <= 1'b1;
          in_data_byte <= nxt.data;
          in_from_aux  <= nxt.aux;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver hold-off counter.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_left <= HOLD_CYCLES;
      hold_seen <= hold_req;
    end
  end

  // Monitor. Every report taken is compared field by field with the oldest
  // prediction; pop is then redrawn for the next cycle.
  always @(posedge clk) begin : check_reports
    res_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (cursor_reports_due.size() == 0) begin
          report_mismatch("report word arrived with none outstanding");
        end else begin
          want = cursor_reports_due.pop_front();
          if (out_pos_x !== want.pos_x)
            report_mismatch($sformatf("pos_x got %0d want %0d", out_pos_x, want.pos_x));
          if (out_pos_y !== want.pos_y)
            report_mismatch($sformatf("pos_y got %0d want %0d", out_pos_y, want.pos_y));
          if (out_button_bits !== want.button_bits)
            report_mismatch($sformatf("button_bits got %0h want %0h",
                                      out_button_bits, want.button_bits));
          if (out_packets_seen !== want.packets_seen)
            report_mismatch($sformatf("packets_seen got %0d want %0d",
                                      out_packets_seen, want.packets_seen));
          if (out_bytes_seen !== want.bytes_seen)
            report_mismatch($sformatf("bytes_seen got %0d want %0d",
                                      out_bytes_seen, want.bytes_seen));
        end
      end
      pop <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic aux);
    byte_backlog.push_back('{data: b, aux: aux});
  endtask

  // Deltas lean toward the extremes so that the clamps are hit often.
  function automatic logic [7:0] random_delta();
    case ($urandom_range(9))
      0: return 8'h7F;
      1: return 8'h80;
      2: return 8'h00;
      3: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly well-formed packets with random content, sometimes with a
  // keyboard byte slipped in between; the rest is keyboard noise, stray mouse
  // bytes and packets cut short. drift_pct forces a move right and down so
  // the cursor can reach the far edges of a large screen.
  task automatic queue_random_traffic(input int aux_words, input int drift_pct);
    int         sent;
    int         pick;
    logic [7:0] head;
    logic [7:0] dx;
    logic [7:0] dy;
    sent = 0;
    while (sent < aux_words) begin
      pick = $urandom_range(99);
      head = 8'($urandom) | START_MARK;
      dx   = random_delta();
      dy   = random_delta();
      if ($urandom_range(99) < drift_pct) begin
        dx = 8'h7F;
        dy = 8'h80;
      end
      if (pick < 72) begin
        queue_byte(head, 1'b1);
        if ($urandom_range(9) == 0) queue_byte(8'($urandom), 1'b0);
        queue_byte(dx, 1'b1);
        if ($urandom_range(9) == 0) queue_byte(8'($urandom), 1'b0);
        queue_byte(dy, 1'b1);
        sent += 3;
      end else if (pick < 82) begin
        queue_byte(8'($urandom), 1'b0);
      end else if (pick < 92) begin
        // Half of these lack the start mark and are thrown away at a start.
        if ($urandom_range(1) == 0) queue_byte(8'($urandom) & ~START_MARK, 1'b1);
        else queue_byte(8'($urandom), 1'b1);
        sent += 1;
      end else begin
        queue_byte(head, 1'b1);
        sent += 1;
        if ($urandom_range(1) == 0) begin
          queue_byte(dx, 1'b1);
          sent += 1;
        end
      end
    end
  endtask

  // The sender stops here until every predicted report has come back and a
  // partial packet or a dropped byte has had time to settle.
  task automatic wait_until_idle();
    do @(negedge clk);
    while (byte_backlog.size() != 0 || push || cursor_reports_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_SCREEN_WIDTH) scr_width = saturate_size(val);
    else scr_height = saturate_size(val);
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("ERROR: run timed out with %0d reports outstanding",
             cursor_reports_due.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Main sequence: reset, a directed part at the reset screen size and at the
  // size extremes, then four phases of random traffic, each under its own
  // screen size and idle pattern.
  initial begin
    logic [CFG_DATA_W-1:0] width_of[PHASES];
    logic [CFG_DATA_W-1:0] height_of[PHASES];
    int                    idle_of[PHASES];
    int                    stall_of[PHASES];
    int                    drift_of[PHASES];

    width_of  = '{13'd4096, 13'd0, 13'd1, 13'd1};
    height_of = '{13'h1FFF, 13'd1, 13'd1, 13'd1};
    width_of[2]  = 13'($urandom_range(300, 2));
    height_of[2] = 13'($urandom_range(300, 2));
    width_of[3]  = 13'($urandom_range(4096, 1));
    height_of[3] = 13'($urandom_range(4096, 1));
    idle_of  = '{0, 72, 0, 34};
    stall_of = '{0, 0, 72, 34};
    drift_of = '{30, 0, 0, 5};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Keyboard bytes are dropped, mouse start bytes without the mark are only
    // counted, and the first packet sets every button and overflow bit while
    // moving by the largest deltas. A keyboard byte inside a packet must not
    // disturb it.
    @(negedge clk);
    queue_byte(8'hFF, 1'b0);
    queue_byte(START_MARK, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hF7, 1'b1);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h7F, 1'b1);
    queue_byte(8'h80, 1'b1);
    queue_byte(START_MARK, 1'b1);
    queue_byte(8'h80, 1'b1);
    queue_byte(8'h7F, 1'b1);
    queue_byte(8'h09, 1'b1);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'h0A, 1'b1);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'h01, 1'b1);
    queue_byte(8'hFF, 1'b1);
    wait_until_idle();

    // A zero width acts as one column, and an oversized height saturates.
    write_reg(REG_SCREEN_WIDTH, 13'd0);
    write_reg(REG_SCREEN_HEIGHT, 13'h1FFF);
    @(negedge clk);
    queue_byte(8'h0C, 1'b1);
    queue_byte(8'h80, 1'b1);
    queue_byte(8'h80, 1'b1);
    wait_until_idle();

    // The row now lies beyond a one-row screen until the next packet clamps it.
    write_reg(REG_SCREEN_WIDTH, 13'd4096);
    write_reg(REG_SCREEN_HEIGHT, 13'd1);
    @(negedge clk);
    queue_byte(8'h0E, 1'b1);
    queue_byte(8'h7F, 1'b1);
    queue_byte(8'h7F, 1'b1);
    wait_until_idle();

    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_SCREEN_WIDTH, width_of[p]);
      write_reg(REG_SCREEN_HEIGHT, height_of[p]);
      @(negedge clk);
      send_idle_pct  = idle_of[p];
      recv_stall_pct = stall_of[p];
      queue_random_traffic(HALF_PHASE, drift_of[p]);
      // In the first phase the receiver holds off while the sender keeps
      // offering words back to back, so the block fills and raises full.
      if (p == 0) hold_req <= ~hold_req;
      wait_until_idle();
      @(negedge clk);
      queue_random_traffic(HALF_PHASE, drift_of[p]);
      wait_until_idle();
    end

    if (cursor_reports_due.size() != 0)
      report_mismatch($sformatf("%0d reports never delivered", cursor_reports_due.size()));
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
